FILE: hw/rtl/akd_pkg.sv
// ----------------------------------------------------------------------------
// akd_pkg: shared types and constants
// Field widths, register indexes, level and event codes for the ladder
// key press detector.
// ----------------------------------------------------------------------------
`default_nettype none

package akd_pkg;

  localparam int unsigned MV_W     = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  typedef logic [1:0] level_t;
  localparam level_t LEVEL_NONE   = 2'd0;
  localparam level_t LEVEL_FIRST  = 2'd1;
  localparam level_t LEVEL_SECOND = 2'd2;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t EVT_NONE    = 2'd0;
  localparam kind_t EVT_PRESS   = 2'd1;
  localparam kind_t EVT_RELEASE = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_LOW_THR   = 3'd0;
  localparam cfg_idx_t REG_HIGH_THR  = 3'd1;
  localparam cfg_idx_t REG_LONG_LIM  = 3'd2;
  localparam cfg_idx_t REG_FIRST_KEY = 3'd3;
  localparam cfg_idx_t REG_SECOND_KEY = 3'd4;

  typedef struct packed {
    logic [MV_W-1:0]   low_thr;
    logic [MV_W-1:0]   high_thr;
    logic [TIME_W-1:0] long_limit;
    logic [CODE_W-1:0] first_key;
    logic [CODE_W-1:0] second_key;
  } akd_cfg_t;

  typedef struct packed {
    kind_t             event_kind;
    logic [CODE_W-1:0] key_code;
    logic              held_long;
    logic [TIME_W-1:0] duration_ms;
  } akd_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/akd_ifs.sv
// ----------------------------------------------------------------------------
// akd_ifs: channel interfaces
// Sample input, event output and register write channels, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface akd_sample_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_mv;
  logic [31:0] now_ms;

  modport source (output valid, output sample_mv, output now_ms, input ready);
  modport sink   (input valid, input sample_mv, input now_ms, output ready);
endinterface

interface akd_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  key_code;
  logic        held_long;
  logic [31:0] duration_ms;

  modport source (output valid, output event_kind, output key_code,
                  output held_long, output duration_ms, input ready);
  modport sink   (input valid, input event_kind, input key_code,
                  input held_long, input duration_ms, output ready);
endinterface

interface akd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/adc_ladder_key_press_detector.sv
// ----------------------------------------------------------------------------
// adc_ladder_key_press_detector: two-key resistor ladder press detector
// Turns ladder voltage samples into press start and release events.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries one millivolt sample and its millisecond time per
//   transfer. Every sample yields exactly one transfer on result_ch: event
//   kind (none, press start, release), key code, long press flag and the
//   press duration on a release.
//   cfg writes the five registers by index (thresholds, long press limit,
//   key codes); it is always ready and should only be written while no
//   sample is in flight. Unknown indexes are dropped.
// Timing:
//   A sample is captured in the input register, classified and decided from
//   there, and its result lands in the output register once that register is
//   free or drains. One sample per cycle is sustained while result_ch keeps
//   ready high; the level history and time mark update as the sample moves
//   to the output register, so back-to-back samples see each other's state.
// Reset (rst, synchronous): registers return to their defaults, level history
//   to no key, the time mark to zero and both pipeline stages empty.
// Stall: when result_ch holds back ready the output register holds its
//   result, the input register fills, and sample_ch drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_ladder_key_press_detector (
  input  logic        clk,
  input  logic        rst,
  akd_sample_if.sink  sample_ch,
  akd_event_if.source result_ch,
  akd_cfg_if.sink     cfg
);
  import akd_pkg::*;

  akd_cfg_t    cfg_q;
  akd_result_t result_comb;
  level_t      level_new;
  logic [TIME_W-1:0] time_mark_next;

  // Input stage
  logic              in_valid;
  logic [MV_W-1:0]   in_mv;
  logic [TIME_W-1:0] in_time;

  // Detector state
  level_t            hist_newer;
  level_t            hist_older;
  logic [TIME_W-1:0] time_mark;

  // Output stage
  logic        out_valid;
  akd_result_t out_data;

  logic advance;
  logic in_take;

  assign cfg.ready = 1'b1;

  akd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  akd_event_logic u_event_logic (
    .cfg            (cfg_q),
    .sample_mv      (in_mv),
    .now_ms         (in_time),
    .hist_newer     (hist_newer),
    .hist_older     (hist_older),
    .time_mark      (time_mark),
    .level_new      (level_new),
    .time_mark_next (time_mark_next),
    .result         (result_comb)
  );

  // Move the captured sample on when the output register is free or drains.
  assign advance         = in_valid && (!out_valid || result_ch.ready);
  assign sample_ch.ready = !in_valid || advance;
  assign in_take         = sample_ch.valid && sample_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_mv   <= sample_ch.sample_mv;
      in_time <= sample_ch.now_ms;
    end
  end

  // Commit history and time mark only as the sample leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_newer <= LEVEL_NONE;
      hist_older <= LEVEL_NONE;
      time_mark  <= '0;
    end else if (advance) begin
      hist_newer <= level_new;
      hist_older <= hist_newer;
      time_mark  <= time_mark_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_comb;
    end
  end

  assign result_ch.valid       = out_valid;
  assign result_ch.event_kind  = out_data.event_kind;
  assign result_ch.key_code    = out_data.key_code;
  assign result_ch.held_long   = out_data.held_long;
  assign result_ch.duration_ms = out_data.duration_ms;

endmodule

`default_nettype wire

FILE: hw/rtl/akd_cfg_regs.sv
// ----------------------------------------------------------------------------
// akd_cfg_regs: configuration register file
// Holds thresholds, long press limit and key codes; writes to unknown
// indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module akd_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  akd_pkg::cfg_idx_t     wr_index,
  input  logic [31:0]           wr_data,
  output akd_pkg::akd_cfg_t     cfg
);
  import akd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_thr    <= MV_W'(1000);
      cfg.high_thr   <= MV_W'(2000);
      cfg.long_limit <= TIME_W'(1000);
      cfg.first_key  <= CODE_W'(1);
      cfg.second_key <= CODE_W'(2);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LOW_THR:    cfg.low_thr    <= wr_data[MV_W-1:0];
        REG_HIGH_THR:   cfg.high_thr   <= wr_data[MV_W-1:0];
        REG_LONG_LIM:   cfg.long_limit <= wr_data[TIME_W-1:0];
        REG_FIRST_KEY:  cfg.first_key  <= wr_data[CODE_W-1:0];
        REG_SECOND_KEY: cfg.second_key <= wr_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/akd_event_logic.sv
// ----------------------------------------------------------------------------
// akd_event_logic: sample classification and window decision
// Classifies one sample, judges the three-level window and forms the
// result together with the next time mark.
// ----------------------------------------------------------------------------
`default_nettype none

module akd_event_logic (
  input  akd_pkg::akd_cfg_t    cfg,
  input  logic [11:0]          sample_mv,
  input  logic [31:0]          now_ms,
  input  akd_pkg::level_t      hist_newer,
  input  akd_pkg::level_t      hist_older,
  input  logic [31:0]          time_mark,
  output akd_pkg::level_t      level_new,
  output logic [31:0]          time_mark_next,
  output akd_pkg::akd_result_t result
);
  import akd_pkg::*;

  logic [1:0]        ones;
  logic [1:0]        twos;
  logic              press;
  logic              release_hit;
  logic [TIME_W-1:0] elapsed;

  // Low threshold is tested first, so inverted thresholds never give level two
  // for a sample below the low one.
  always_comb begin
    if (sample_mv < cfg.low_thr) begin
      level_new = LEVEL_NONE;
    end else if (sample_mv < cfg.high_thr) begin
      level_new = LEVEL_FIRST;
    end else begin
      level_new = LEVEL_SECOND;
    end
  end

  assign ones = 2'(level_new == LEVEL_FIRST) + 2'(hist_newer == LEVEL_FIRST)
              + 2'(hist_older == LEVEL_FIRST);
  assign twos = 2'(level_new == LEVEL_SECOND) + 2'(hist_newer == LEVEL_SECOND)
              + 2'(hist_older == LEVEL_SECOND);

  assign press       = (ones == 2'd2 || twos == 2'd2) && (level_new != LEVEL_NONE);
  assign release_hit = (level_new == LEVEL_NONE) && (hist_newer == LEVEL_NONE)
                     && (hist_older != LEVEL_NONE);
  assign elapsed     = now_ms - time_mark;

  always_comb begin
    result         = '0;
    time_mark_next = time_mark;
    if (press) begin
      time_mark_next    = now_ms;
      result.event_kind = EVT_PRESS;
      result.key_code   = (level_new == LEVEL_FIRST) ? cfg.first_key : cfg.second_key;
    end else if (release_hit) begin
      time_mark_next     = elapsed;
      result.event_kind  = EVT_RELEASE;
      result.key_code    = (hist_older == LEVEL_FIRST) ? cfg.first_key : cfg.second_key;
      result.held_long   = elapsed > cfg.long_limit;
      result.duration_ms = elapsed;
    end
  end

endmodule

`default_nettype wire
